// ===== hw/rtl/spmf_pkg.sv =====
// ----------------------------------------------------------------------------
// spmf_pkg
// Shared widths, operation and status codes, and controller/datapath
// command and status structs for the strict-priority multilevel queue.
// ----------------------------------------------------------------------------
package spmf_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 2;
    localparam int PRIO_W = 8;
    localparam int STAT_W = 2;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_EMPTY   = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_INVALID = 2'd3;

    typedef struct packed {
        logic in_ready;
        logic capture;
        logic execute;
        logic emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== hw/rtl/spmf_req_if.sv =====
// ----------------------------------------------------------------------------
// spmf_req_if
// Request channel: operation, priority level and data word with
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface spmf_req_if;
    import spmf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic [PRIO_W-1:0]        priority_req;
    logic signed [DATA_W-1:0] data_in;

    modport source (output valid, operation, priority_req, data_in, input ready);
    modport sink   (input valid, operation, priority_req, data_in, output ready);
endinterface

// ===== hw/rtl/spmf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// spmf_rsp_if
// Response channel: data word, status and all-empty flag with
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface spmf_rsp_if;
    import spmf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] data_out;
    logic [STAT_W-1:0]        status;
    logic                     all_empty;

    modport source (output valid, data_out, status, all_empty, input ready);
    modport sink   (input valid, data_out, status, all_empty, output ready);
endinterface

// ===== hw/rtl/spmf_ctrl.sv =====
// ----------------------------------------------------------------------------
// spmf_ctrl
// Controller: sequences one request through capture, execute and emit,
// and issues the datapath commands for each step.
// ----------------------------------------------------------------------------
module spmf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  spmf_pkg::dp_stat_t stat,
    output spmf_pkg::ctl_cmd_t cmd
);
    import spmf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.capture  = stat.in_valid;
                if (stat.in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_exec_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC |=> state_reg == ST_EMIT)
        else $error("execute step not followed by emit");

    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && !stat.out_free) |=> state_reg == ST_EMIT)
        else $error("emit left while output register busy");

endmodule

// ===== hw/rtl/spmf_datapath.sv =====
// ----------------------------------------------------------------------------
// spmf_datapath
// Datapath: level table (head and count per level), word store, level
// occupancy flags, priority encoder and output register.
// ----------------------------------------------------------------------------
module spmf_datapath #(
    parameter int LEVELS = 8,
    parameter int DEPTH  = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  spmf_pkg::ctl_cmd_t cmd,
    output spmf_pkg::dp_stat_t stat,
    spmf_req_if.sink           req,
    spmf_rsp_if.source         rsp
);
    import spmf_pkg::*;

    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORDS  = LEVELS * DEPTH;
    localparam int ADDR_W = $clog2(WORDS);

    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(DEPTH - 1);
    localparam logic [SLOT_W:0]   SUM_DEPTH = (SLOT_W + 1)'(DEPTH);
    localparam logic [PRIO_W-1:0] PRIO_MAX  = PRIO_W'(LEVELS);
    localparam logic [ADDR_W-1:0] ROW_SIZE  = ADDR_W'(DEPTH);

    logic [SLOT_W-1:0]        head_mem [LEVELS];
    logic [CNT_W-1:0]         cnt_mem  [LEVELS];
    logic signed [DATA_W-1:0] word_mem [WORDS];

    logic [LEVELS-1:0]        lvl_valid_reg;
    logic [LEVELS-1:0]        nonempty_reg;
    logic                     out_valid_reg;

    logic [OP_W-1:0]          op_reg;
    logic signed [DATA_W-1:0] data_reg;
    logic                     prio_ok_reg;
    logic                     any_reg;
    logic [LVL_W-1:0]         lvl_reg;
    logic                     ent_valid_reg;
    logic [SLOT_W-1:0]        head_rd_reg;
    logic [CNT_W-1:0]         cnt_rd_reg;
    logic signed [DATA_W-1:0] res_data_reg;
    logic [STAT_W-1:0]        res_status_reg;
    logic                     from_mem_reg;
    logic signed [DATA_W-1:0] word_rd_reg;
    logic signed [DATA_W-1:0] out_data_reg;
    logic [STAT_W-1:0]        out_status_reg;
    logic                     out_all_empty_reg;

    logic                     prio_ok;
    logic [LVL_W-1:0]         add_lvl;
    logic [LVL_W-1:0]         enc_lvl;
    logic [LVL_W-1:0]         sel_lvl;
    logic [SLOT_W-1:0]        cur_head;
    logic [CNT_W-1:0]         cur_cnt;
    logic [SLOT_W:0]          tail_sum;
    logic [SLOT_W-1:0]        tail_slot;
    logic [SLOT_W-1:0]        next_head;
    logic [ADDR_W-1:0]        lvl_base;
    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     do_add;
    logic                     do_rem;
    logic                     do_clr;
    logic signed [DATA_W-1:0] res_data_next;
    logic [STAT_W-1:0]        res_status_next;

    assign req.ready     = cmd.in_ready;
    assign stat.in_valid = req.valid;
    assign stat.out_free = !out_valid_reg || rsp.ready;

    assign prio_ok = (req.priority_req != '0) && (req.priority_req <= PRIO_MAX);
    assign add_lvl = prio_ok ? LVL_W'(req.priority_req - PRIO_W'(1)) : '0;

    always_comb
    begin
        enc_lvl = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (nonempty_reg[i])
            begin
                enc_lvl = LVL_W'(i);
            end
        end
    end

    assign sel_lvl = (req.operation == OP_REMOVE) ? enc_lvl : add_lvl;

    assign cur_head  = ent_valid_reg ? head_rd_reg : '0;
    assign cur_cnt   = ent_valid_reg ? cnt_rd_reg : '0;
    assign tail_sum  = {1'b0, cur_head} + (SLOT_W + 1)'(cur_cnt);
    assign tail_slot = (tail_sum >= SUM_DEPTH) ? SLOT_W'(tail_sum - SUM_DEPTH)
                                               : SLOT_W'(tail_sum);
    assign next_head = (cur_head == SLOT_LAST) ? '0 : SLOT_W'(cur_head + 1'b1);
    assign lvl_base  = ADDR_W'(ADDR_W'(lvl_reg) * ROW_SIZE);
    assign wr_addr   = ADDR_W'(lvl_base + ADDR_W'(tail_slot));
    assign rd_addr   = ADDR_W'(lvl_base + ADDR_W'(cur_head));

    assign do_add = cmd.execute && (op_reg == OP_ADD) && prio_ok_reg
                    && (cur_cnt != CNT_FULL);
    assign do_rem = cmd.execute && (op_reg == OP_REMOVE) && any_reg;
    assign do_clr = cmd.execute && (op_reg == OP_CLEAR);

    always_comb
    begin
        res_data_next   = '0;
        res_status_next = STATUS_OK;
        case (op_reg)
            OP_ADD:
            begin
                if (!prio_ok_reg)
                begin
                    res_status_next = STATUS_INVALID;
                end
                else if (cur_cnt == CNT_FULL)
                begin
                    res_status_next = STATUS_FULL;
                end
                else
                begin
                    res_data_next = data_reg;
                end
            end
            OP_REMOVE:
            begin
                if (!any_reg)
                begin
                    res_status_next = STATUS_EMPTY;
                end
            end
            default:
            begin
                res_status_next = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_valid_reg <= '0;
            nonempty_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_clr)
            begin
                lvl_valid_reg <= '0;
                nonempty_reg  <= '0;
            end
            else if (do_add)
            begin
                lvl_valid_reg[lvl_reg] <= 1'b1;
                nonempty_reg[lvl_reg]  <= 1'b1;
            end
            else if (do_rem && (cur_cnt == CNT_ONE))
            begin
                nonempty_reg[lvl_reg] <= 1'b0;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg        <= req.operation;
            data_reg      <= req.data_in;
            prio_ok_reg   <= prio_ok;
            any_reg       <= |nonempty_reg;
            lvl_reg       <= sel_lvl;
            ent_valid_reg <= lvl_valid_reg[sel_lvl];
        end
        if (cmd.execute)
        begin
            res_data_reg   <= res_data_next;
            res_status_reg <= res_status_next;
            from_mem_reg   <= do_rem;
        end
        if (cmd.emit)
        begin
            out_data_reg      <= from_mem_reg ? word_rd_reg : res_data_reg;
            out_status_reg    <= res_status_reg;
            out_all_empty_reg <= ~|nonempty_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            head_rd_reg <= head_mem[sel_lvl];
            cnt_rd_reg  <= cnt_mem[sel_lvl];
        end
        if (do_add)
        begin
            head_mem[lvl_reg] <= cur_head;
            cnt_mem[lvl_reg]  <= CNT_W'(cur_cnt + 1'b1);
        end
        else if (do_rem)
        begin
            head_mem[lvl_reg] <= next_head;
            cnt_mem[lvl_reg]  <= CNT_W'(cur_cnt - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_add)
        begin
            word_mem[wr_addr] <= data_reg;
        end
        if (do_rem)
        begin
            word_rd_reg <= word_mem[rd_addr];
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.data_out  = out_data_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.all_empty = out_all_empty_reg;

    a_occupied_is_written: assert property (@(posedge clk) disable iff (!rst_n)
        (nonempty_reg & ~lvl_valid_reg) == '0)
        else $error("occupied level without a written table entry");

    a_remove_hits_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        do_rem |-> nonempty_reg[lvl_reg] && cur_cnt != '0)
        else $error("remove selected an empty level");

    a_empty_status_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && res_status_reg == STATUS_EMPTY) |=> rsp.all_empty)
        else $error("empty status reported with occupied levels");

endmodule

// ===== hw/rtl/strict_priority_multi_fifo.sv =====
// ----------------------------------------------------------------------------
// strict_priority_multi_fifo
// Strict-priority multilevel queue: one ring FIFO of DEPTH words per level.
// ----------------------------------------------------------------------------
// One request at a time: a request is taken in the idle state, the level
// table (head and count) is read into a register, the execute step updates
// the ring and reads or writes the word store, and the emit step loads the
// output register once the output register is free (it waits otherwise); the
// controller then returns to idle to take the next request. The steps are set
// by the registered read of the level table followed by the registered
// read of the word store. A remove serves the lowest-numbered non-empty level
// through a priority encoder over the level occupancy flags. The word store
// needs no initialization pass; level state is cleared at reset at once.
// The output register lets a new request be taken while a response waits.
module strict_priority_multi_fifo #(
    parameter int LEVELS = 8,
    parameter int DEPTH  = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    spmf_req_if.sink   req,
    spmf_rsp_if.source rsp
);
    import spmf_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    spmf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    spmf_datapath #(
        .LEVELS (LEVELS),
        .DEPTH  (DEPTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

// ===== sim/spmf_scoreboard.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spmf_scoreboard
// Watches the request and response channels of the strict-priority queue,
// keeps its own copy of every level's ring and of the word store, predicts
// the response of each accepted request and compares it field by field with
// the responses that come out, in order.
// ----------------------------------------------------------------------------
module spmf_scoreboard #(
    parameter int LEVELS = 8,
    parameter int DEPTH  = 8
) (
    input  logic clk,
    input  logic rst_n,
    spmf_req_if  req,
    spmf_rsp_if  rsp,
    output int   fail_count,
    output int   outstanding
);
    import spmf_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [STAT_W-1:0]        status;
        logic                     all_empty;
    } rsp_word_t;

    logic [DATA_W-1:0] level_words [LEVELS*DEPTH];
    int unsigned       level_rd_ptr [LEVELS];
    int unsigned       level_fill [LEVELS];
    rsp_word_t         pending_responses [$];
    int                reported;

    function automatic bit levels_empty();
        bit empty;
        empty = 1'b1;
        for (int lv = 0; lv < LEVELS; lv++)
        begin
            if (level_fill[lv] != 0)
                empty = 1'b0;
        end
        return empty;
    endfunction

    function automatic rsp_word_t queue_outcome(input logic [OP_W-1:0] op,
                                                input logic [PRIO_W-1:0] prio,
                                                input logic [DATA_W-1:0] word);
        rsp_word_t   r;
        int unsigned lv;
        int unsigned slot;
        bit          found;
        r.data   = '0;
        r.status = STATUS_OK;
        found    = 1'b0;
        case (op)
            OP_ADD:
            begin
                if (prio < 1 || prio > LEVELS)
                    r.status = STATUS_INVALID;
                else
                begin
                    lv = prio - 1;
                    if (level_fill[lv] >= DEPTH)
                        r.status = STATUS_FULL;
                    else
                    begin
                        slot = (level_rd_ptr[lv] + level_fill[lv]) % DEPTH;
                        level_words[lv*DEPTH + slot] = word;
                        level_fill[lv] = level_fill[lv] + 1;
                        r.data = word;
                    end
                end
            end
            OP_REMOVE:
            begin
                r.status = STATUS_EMPTY;
                for (lv = 0; lv < LEVELS; lv++)
                begin
                    if (!found && level_fill[lv] != 0)
                    begin
                        found = 1'b1;
                        slot = level_rd_ptr[lv] % DEPTH;
                        r.data = level_words[lv*DEPTH + slot];
                        level_rd_ptr[lv] = (slot + 1) % DEPTH;
                        level_fill[lv] = level_fill[lv] - 1;
                        r.status = STATUS_OK;
                    end
                end
            end
            OP_CLEAR:
            begin
                for (lv = 0; lv < LEVELS; lv++)
                begin
                    level_rd_ptr[lv] = 0;
                    level_fill[lv]   = 0;
                end
            end
            default:
            begin
            end
        endcase
        r.all_empty = levels_empty();
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_word_t exp_rsp;
        if (!rst_n)
        begin
            for (int lv = 0; lv < LEVELS; lv++)
            begin
                level_rd_ptr[lv] = 0;
                level_fill[lv]   = 0;
            end
            for (int i = 0; i < LEVELS*DEPTH; i++)
                level_words[i] = '0;
            pending_responses.delete();
            fail_count  <= 0;
            outstanding <= 0;
            reported    = 0;
        end
        else
        begin
            // check the oldest expectation before queuing a new one
            if (rsp.valid && rsp.ready)
            begin
                if (pending_responses.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (reported < 10)
                        $display("%0t: unexpected response data %h status %0d empty %0b",
                                 $realtime, rsp.data_out, rsp.status, rsp.all_empty);
                    reported++;
                end
                else
                begin
                    exp_rsp = pending_responses.pop_front();
                    if (rsp.data_out !== exp_rsp.data || rsp.status !== exp_rsp.status ||
                        rsp.all_empty !== exp_rsp.all_empty)
                    begin
                        fail_count <= fail_count + 1;
                        if (reported < 10)
                            $display("%0t: mismatch: expected data %h status %0d empty %0b, got data %h status %0d empty %0b",
                                     $realtime, exp_rsp.data, exp_rsp.status,
                                     exp_rsp.all_empty, rsp.data_out, rsp.status,
                                     rsp.all_empty);
                        reported++;
                    end
                end
            end
            if (req.valid && req.ready)
                pending_responses.push_back(queue_outcome(req.operation, req.priority_req,
                                                          req.data_in));
            outstanding <= pending_responses.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the strict-priority multilevel queue: a directed pass over
// invalid levels, full and empty levels, extreme words, no-op and clear,
// then random add/remove phases with random gaps and response stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import spmf_pkg::*;

    localparam int LEVELS       = 8;
    localparam int DEPTH        = 8;
    localparam int RANDOM_ITEMS = 600;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;

    logic        clk;
    logic        rst_n;
    int          fail_count;
    int          outstanding;
    int unsigned cycle_count = 0;
    bit          req_quiet;
    bit          rsp_quiet;

    spmf_req_if req ();
    spmf_rsp_if rsp ();

    strict_priority_multi_fifo #(
        .LEVELS (LEVELS),
        .DEPTH  (DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    spmf_scoreboard #(
        .LEVELS (LEVELS),
        .DEPTH  (DEPTH)
    ) scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp.ready <= rsp_quiet || ($urandom_range(99) >= 18);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_request(input logic [OP_W-1:0] op, input logic [PRIO_W-1:0] prio,
                                input logic [DATA_W-1:0] word);
        while (!req_quiet && $urandom_range(99) < 18)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.operation    <= op;
        req.priority_req <= prio;
        req.data_in      <= word;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    task automatic random_request(input int add_share);
        int                r;
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] word;
        r    = $urandom_range(99);
        prio = 8'($urandom_range(255));
        word = $urandom;
        if ($urandom_range(9) == 0)
            word = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        if (r < add_share)
        begin
            prio = $urandom_range(1) ? 8'($urandom_range(3, 1)) : 8'($urandom_range(LEVELS, 1));
            send_request(OP_ADD, prio, word);
        end
        else if (r < 88)
            send_request(OP_REMOVE, prio, word);
        else if (r < 93)
        begin
            prio = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, LEVELS + 1));
            send_request(OP_ADD, prio, word);
        end
        else if (r < 97)
            send_request(OP_NOP, prio, word);
        else
            send_request(OP_CLEAR, prio, word);
    endtask

    initial
    begin
        req_quiet = 1'b0;
        rsp_quiet = 1'b0;
        rst_n            <= 1'b0;
        req.valid        <= 1'b0;
        req.operation    <= OP_NOP;
        req.priority_req <= '0;
        req.data_in      <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_REMOVE, 8'd1, 32'h0);
        send_request(OP_ADD, 8'd0, 32'h1234_5678);
        send_request(OP_ADD, 8'd255, 32'hFFFF_FFFF);
        send_request(OP_ADD, 8'(LEVELS + 1), 32'h0BAD_0BAD);
        send_request(OP_ADD, 8'd1, 32'h7FFF_FFFF);
        send_request(OP_ADD, 8'(LEVELS), 32'h8000_0000);
        for (int k = 0; k < DEPTH + 1; k++)
            send_request(OP_ADD, 8'd3, 32'h1000_0000 + k);
        send_request(OP_REMOVE, 8'd0, 32'hFFFF_FFFF);
        send_request(OP_REMOVE, 8'd0, 32'h0);
        send_request(OP_REMOVE, 8'd0, 32'h0);
        send_request(OP_NOP, 8'd5, 32'h5555_AAAA);
        send_request(OP_CLEAR, 8'd2, 32'h0);
        send_request(OP_REMOVE, 8'd1, 32'h0);
        send_request(OP_ADD, 8'd2, 32'h0000_0000);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            req_quiet = (i >= 300 && i < 400);
            rsp_quiet = req_quiet;
            random_request(((i / 75) % 2 == 0) ? 62 : 30);
        end
        req.valid <= 1'b0;
        req_quiet = 1'b0;
        rsp_quiet = 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
